>>> rtl/core/round_robin_dispatcher_core_defines.svh
// Assertion macros shared by the dispatcher RTL
`ifndef ROUND_ROBIN_DISPATCHER_CORE_DEFINES_SVH
`define ROUND_ROBIN_DISPATCHER_CORE_DEFINES_SVH

// Check a property on every rising edge of clk outside reset
`define RRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rrd_pkg.sv
`default_nettype none

package rrd_pkg;

    localparam int MAX_PROCS     = 64;
    localparam int SLOT_W        = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W         = SLOT_W + 1;
    localparam int ID_W          = 16;
    localparam int BURST_W       = 24;
    localparam int CLK_W         = 30;
    localparam int SLOT_OUT_W    = 6;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = 24'd4;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    process_id;
        logic [BURST_W-1:0] burst_len;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]       dispatched_id;
        logic [SLOT_OUT_W-1:0] slot;
        logic [BURST_W-1:0]    slice_length;
        logic                  finished;
        logic [CLK_W-1:0]      turnaround;
        logic                  all_done;
    } result_t;

    typedef struct packed {
        logic               loaded;
        logic               pending;
        logic               started;
        logic [SLOT_W-1:0]  tag;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] remaining;
        logic [CLK_W-1:0]   first_start;
    } cell_t;

    typedef struct packed {
        logic               clear;
        logic               shift;
        logic               update;
        logic               load;
        logic [SLOT_W-1:0]  load_slot;
        logic [ID_W-1:0]    load_id;
        logic [BURST_W-1:0] load_burst;
        logic [BURST_W-1:0] upd_remaining;
        logic               upd_pending;
        logic [CLK_W-1:0]   upd_first_start;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/rrd_cell.sv
`default_nettype none

module rrd_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  rrd_pkg::cell_ctrl_t             ctrl,
    input  wire logic [rrd_pkg::SLOT_W-1:0] home_tag,
    input  wire logic                       upd_en,
    input  rrd_pkg::cell_t                  nbr,
    output rrd_pkg::cell_t                  contents
);

    rrd_pkg::cell_t contents_reg;
    rrd_pkg::cell_t contents_next;
    rrd_pkg::cell_t reset_val;

    always_comb
    begin
        reset_val     = '0;
        reset_val.tag = home_tag;
    end

    always_comb
    begin
        contents_next = contents_reg;
        priority if (ctrl.clear)
        begin
            contents_next.loaded  = 1'b0;
            contents_next.pending = 1'b0;
            contents_next.started = 1'b0;
            contents_next.tag     = home_tag;
        end
        else if (upd_en && ctrl.update)
        begin
            contents_next.remaining   = ctrl.upd_remaining;
            contents_next.pending     = ctrl.upd_pending;
            contents_next.started     = 1'b1;
            contents_next.first_start = ctrl.upd_first_start;
        end
        else if (ctrl.shift)
        begin
            contents_next = nbr;
        end
        else if (ctrl.load && (contents_reg.tag == ctrl.load_slot))
        begin
            contents_next.loaded      = 1'b1;
            contents_next.pending     = (ctrl.load_burst != '0);
            contents_next.started     = 1'b0;
            contents_next.id          = ctrl.load_id;
            contents_next.remaining   = ctrl.load_burst;
            contents_next.first_start = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contents_reg <= reset_val;
        end
        else
        begin
            contents_reg <= contents_next;
        end
    end

    assign contents = contents_reg;

endmodule

`default_nettype wire

>>> rtl/core/round_robin_dispatcher_core.sv
// Round-robin dispatcher. Pulse start with a load or dispatch command while busy is low.
// The process table is a ring of cells, the head cell being the next slot in circular load
// order. A dispatch takes the head slot if it is pending; else the ring rotates one slot per
// cycle past each finished or unloaded slot, and once more past the slot that is dispatched.
// A load gives no result. A dispatch that finds nothing pending clears the table. The result
// is on result for the single cycle that result_valid is high, in the cycle after the dispatch
// ends; the receiver cannot stall it, so capture it then.
// Write the slice quantum through cfg_we and cfg_wdata only while busy is low.
`default_nettype none
`include "round_robin_dispatcher_core_defines.svh"

module round_robin_dispatcher_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  rrd_pkg::cmd_t                    cmd,
    output rrd_pkg::result_t                 result,
    output logic                             result_valid,
    input  wire logic                        cfg_we,
    input  wire logic [rrd_pkg::BURST_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t                          state_reg,        state_next;
    logic [rrd_pkg::SLOT_W-1:0]      cnt_reg,          cnt_next;
    logic [rrd_pkg::CNT_W-1:0]       loaded_count_reg, loaded_count_next;
    logic [rrd_pkg::CLK_W-1:0]       elapsed_reg,      elapsed_next;
    logic [rrd_pkg::BURST_W-1:0]     tq_reg;
    logic [rrd_pkg::ID_W-1:0]        hold_id_reg,      hold_id_next;
    logic [rrd_pkg::SLOT_OUT_W-1:0]  hold_slot_reg,    hold_slot_next;
    logic [rrd_pkg::BURST_W-1:0]     hold_slice_reg,   hold_slice_next;
    logic                            hold_fin_reg,     hold_fin_next;
    logic [rrd_pkg::CLK_W-1:0]       hold_first_reg,   hold_first_next;
    rrd_pkg::result_t                result_reg,       result_next;
    logic                            result_valid_reg, result_valid_next;

    rrd_pkg::cell_ctrl_t             ctrl;
    rrd_pkg::cell_t                  cells [rrd_pkg::MAX_PROCS];
    rrd_pkg::cell_t                  head;

    logic                            accept;
    logic                            step_go;
    logic                            head_hit;
    logic [rrd_pkg::SLOT_W-1:0]      cnt_eff;
    logic [rrd_pkg::BURST_W-1:0]     q_eff;
    logic [rrd_pkg::BURST_W-1:0]     slice;
    logic [rrd_pkg::BURST_W-1:0]     rem_new;
    logic [rrd_pkg::CLK_W-1:0]       first_start;

    genvar gi;
    generate
        for (gi = 0; gi < rrd_pkg::MAX_PROCS; gi++)
        begin : g_cell
            rrd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .home_tag (rrd_pkg::SLOT_W'(gi)),
                .upd_en   (gi == 0),
                .nbr      (cells[(gi + 1) % rrd_pkg::MAX_PROCS]),
                .contents (cells[gi])
            );
        end
    endgenerate

    assign head     = cells[0];
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign step_go  = (accept && (cmd.mode == rrd_pkg::MODE_DISPATCH)) || (state_reg == ST_SEARCH);
    assign cnt_eff  = (state_reg == ST_SEARCH) ? cnt_reg : '0;
    assign head_hit = head.loaded && head.pending;
    assign q_eff    = (tq_reg == '0) ? rrd_pkg::BURST_W'(1) : tq_reg;
    assign slice    = (head.remaining < q_eff) ? head.remaining : q_eff;
    assign rem_new  = head.remaining - slice;
    assign first_start = head.started ? head.first_start : elapsed_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        loaded_count_next = loaded_count_reg;
        elapsed_next      = elapsed_reg;
        hold_id_next      = hold_id_reg;
        hold_slot_next    = hold_slot_reg;
        hold_slice_next   = hold_slice_reg;
        hold_fin_next     = hold_fin_reg;
        hold_first_next   = hold_first_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        ctrl                 = '0;
        ctrl.load_slot       = loaded_count_reg[rrd_pkg::SLOT_W-1:0];
        ctrl.load_id         = cmd.process_id;
        ctrl.load_burst      = cmd.burst_len;
        ctrl.upd_remaining   = rem_new;
        ctrl.upd_pending     = (rem_new != '0);
        ctrl.upd_first_start = first_start;

        unique case (state_reg)
            ST_IDLE, ST_SEARCH:
            begin
                if (step_go)
                begin
                    priority if (head_hit)
                    begin
                        ctrl.update     = 1'b1;
                        elapsed_next    = elapsed_reg + rrd_pkg::CLK_W'(slice);
                        hold_id_next    = head.id;
                        hold_slot_next  = rrd_pkg::SLOT_OUT_W'(head.tag);
                        hold_slice_next = slice;
                        hold_fin_next   = (rem_new == '0);
                        hold_first_next = first_start;
                        state_next      = ST_EMIT;
                    end
                    else if (cnt_eff == rrd_pkg::SLOT_W'(rrd_pkg::MAX_PROCS - 1))
                    begin
                        ctrl.clear           = 1'b1;
                        loaded_count_next    = '0;
                        elapsed_next         = '0;
                        result_next          = '0;
                        result_next.all_done = 1'b1;
                        result_valid_next    = 1'b1;
                        state_next           = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.shift = 1'b1;
                        cnt_next   = cnt_eff + 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
                else if (accept && (loaded_count_reg < rrd_pkg::CNT_W'(rrd_pkg::MAX_PROCS)))
                begin
                    ctrl.load         = 1'b1;
                    loaded_count_next = loaded_count_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                ctrl.shift                = 1'b1;
                result_next.dispatched_id = hold_id_reg;
                result_next.slot          = hold_slot_reg;
                result_next.slice_length  = hold_slice_reg;
                result_next.finished      = hold_fin_reg;
                result_next.turnaround    = hold_fin_reg ? (elapsed_reg - hold_first_reg) : '0;
                result_next.all_done      = 1'b0;
                result_valid_next         = 1'b1;
                state_next                = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            loaded_count_reg <= '0;
            elapsed_reg      <= '0;
            tq_reg           <= rrd_pkg::QUANTUM_RESET;
            hold_id_reg      <= '0;
            hold_slot_reg    <= '0;
            hold_slice_reg   <= '0;
            hold_fin_reg     <= 1'b0;
            hold_first_reg   <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            loaded_count_reg <= loaded_count_next;
            elapsed_reg      <= elapsed_next;
            if (cfg_we)
            begin
                tq_reg <= cfg_wdata;
            end
            hold_id_reg      <= hold_id_next;
            hold_slot_reg    <= hold_slot_next;
            hold_slice_reg   <= hold_slice_next;
            hold_fin_reg     <= hold_fin_next;
            hold_first_reg   <= hold_first_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `RRD_ASSERT_NEXT(a_emit_result, state_reg == ST_EMIT,
        result_valid_reg && !result_reg.all_done, "emit did not produce a dispatch result")
    `RRD_ASSERT(a_done_clears,
        (result_valid_reg && result_reg.all_done)
            |-> (loaded_count_reg == '0 && elapsed_reg == '0),
        "all_done without cleared table")
    `RRD_ASSERT(a_slice_nonzero,
        (result_valid_reg && !result_reg.all_done) |-> (result_reg.slice_length != '0),
        "dispatch with empty slice")
    `RRD_ASSERT(a_search_count, (state_reg == ST_SEARCH) |-> (cnt_reg != '0),
        "search entered without a ring step")

endmodule

`default_nettype wire

>>> dv/round_robin_dispatcher_core_test.sv
`timescale 1ns / 100ps

module round_robin_dispatcher_core_test;

    import rrd_pkg::*;

    localparam int HOLD_CYCLES  = MAX_PROCS + 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_CMDS  = 500;
    localparam int NUM_DIRECTED = 22;

    typedef struct packed {
        bit                 is_cfg;
        logic [BURST_W-1:0] cfg_val;
        cmd_t               c;
        bit                 typed;
        result_t            want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    result_t            result;
    logic               result_valid;
    logic               cfg_we;
    logic [BURST_W-1:0] cfg_wdata;

    logic [ID_W-1:0]    id_tbl    [MAX_PROCS];
    logic [BURST_W-1:0] left_tbl  [MAX_PROCS];
    logic [CLK_W-1:0]   first_tbl [MAX_PROCS];
    logic [MAX_PROCS-1:0] pend_mask;
    logic [MAX_PROCS-1:0] run_mask;
    int unsigned        loaded_n;
    int unsigned        next_pos;
    logic [CLK_W-1:0]   clk_now;
    logic [BURST_W-1:0] quantum_q;

    result_t            slice_q[$];
    int                 fail_cnt;
    int                 cmds_sent;
    bit                 no_gaps;
    dir_row_t           dir_rows [NUM_DIRECTED];

    round_robin_dispatcher_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_table();
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            id_tbl[i]    = '0;
            left_tbl[i]  = '0;
            first_tbl[i] = '0;
        end
        pend_mask = '0;
        run_mask  = '0;
        loaded_n  = 0;
        next_pos  = 0;
        clk_now   = '0;
    endfunction

    function automatic void run_scheduler(input cmd_t c, output bit has_res, output result_t r);
        int unsigned        s;
        int unsigned        pos;
        bit                 found;
        logic [BURST_W-1:0] qv;
        logic [BURST_W-1:0] sl;
        r       = '0;
        has_res = 1'b0;
        found   = 1'b0;
        s       = 0;
        if (c.mode == MODE_LOAD)
        begin
            if (loaded_n < MAX_PROCS)
            begin
                id_tbl[loaded_n]    = c.process_id;
                left_tbl[loaded_n]  = c.burst_len;
                first_tbl[loaded_n] = '0;
                pend_mask[loaded_n] = (c.burst_len != '0);
                run_mask[loaded_n]  = 1'b0;
                loaded_n++;
            end
            return;
        end
        has_res = 1'b1;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            pos = (next_pos + i) % MAX_PROCS;
            if (!found && pos < loaded_n && pend_mask[pos])
            begin
                s     = pos;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            clear_table();
            r.all_done = 1'b1;
            return;
        end
        if (!run_mask[s])
        begin
            run_mask[s]  = 1'b1;
            first_tbl[s] = clk_now;
        end
        qv          = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
        sl          = (left_tbl[s] < qv) ? left_tbl[s] : qv;
        left_tbl[s] = left_tbl[s] - sl;
        clk_now     = clk_now + CLK_W'(sl);
        next_pos    = (s + 1) % MAX_PROCS;
        r.dispatched_id = id_tbl[s];
        r.slot          = SLOT_OUT_W'(s);
        r.slice_length  = sl;
        if (left_tbl[s] == '0)
        begin
            pend_mask[s] = 1'b0;
            r.finished   = 1'b1;
            r.turnaround = clk_now - first_tbl[s];
        end
    endfunction

    function automatic int idle_gap();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic dir_row_t mk_load(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] b);
        dir_row_t row;
        row              = '0;
        row.c.mode       = MODE_LOAD;
        row.c.process_id = id;
        row.c.burst_len  = b;
        return row;
    endfunction

    function automatic dir_row_t mk_disp();
        dir_row_t row;
        row        = '0;
        row.c.mode = MODE_DISPATCH;
        return row;
    endfunction

    function automatic dir_row_t mk_done();
        dir_row_t row;
        row               = mk_disp();
        row.typed         = 1'b1;
        row.want.all_done = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t mk_slice(input logic [ID_W-1:0] id, input int slot,
                                          input logic [BURST_W-1:0] sl, input bit fin,
                                          input logic [CLK_W-1:0] ta);
        dir_row_t row;
        row                    = mk_disp();
        row.typed              = 1'b1;
        row.want.dispatched_id = id;
        row.want.slot          = SLOT_OUT_W'(slot);
        row.want.slice_length  = sl;
        row.want.finished      = fin;
        row.want.turnaround    = ta;
        return row;
    endfunction

    function automatic dir_row_t mk_quantum(input logic [BURST_W-1:0] v);
        dir_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    function automatic cmd_t rand_load(input int unsigned q_eff, input int unsigned rounds);
        cmd_t        c;
        int unsigned cap;
        cap  = q_eff * rounds;
        if (cap > 32'hFF_FFFF)
            cap = 32'hFF_FFFF;
        c.mode       = MODE_LOAD;
        c.process_id = ($urandom_range(0, 15) == 0) ? 16'hFFFF : ID_W'($urandom_range(1, 65535));
        if ($urandom_range(0, 7) == 0)
            c.burst_len = '0;
        else
            c.burst_len = BURST_W'($urandom_range(1, cap));
        return c;
    endfunction

    function automatic cmd_t rand_dispatch();
        cmd_t c;
        c.mode       = MODE_DISPATCH;
        c.process_id = ID_W'($urandom);
        c.burst_len  = BURST_W'($urandom);
        return c;
    endfunction

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_cnt++;
        end
    endtask

    task automatic issue_cmd(input cmd_t c, input bit typed, input result_t want,
                             output result_t got);
        int      gap;
        bit      has_res;
        result_t r;
        gap = idle_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        run_scheduler(c, has_res, r);
        if (has_res)
            slice_q.push_back(typed ? want : r);
        got = r;
        cmds_sent++;
    endtask

    task automatic drain_and_hold();
        start <= 1'b0;
        while (slice_q.size() != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [BURST_W-1:0] v);
        drain_and_hold();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        quantum_q = v;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (slice_q.size() == 0)
            begin
                $error("result with no transaction outstanding");
                fail_cnt++;
            end
            else
            begin
                want = slice_q.pop_front();
                check_field("dispatched_id", 64'(want.dispatched_id),
                            64'(result.dispatched_id));
                check_field("slot", 64'(want.slot), 64'(result.slot));
                check_field("slice_length", 64'(want.slice_length),
                            64'(result.slice_length));
                check_field("finished", 64'(want.finished), 64'(result.finished));
                check_field("turnaround", 64'(want.turnaround), 64'(result.turnaround));
                check_field("all_done", 64'(want.all_done), 64'(result.all_done));
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || cfg_we || result_valid)
                stall = 0;
            else
                stall++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        result_t     got;
        int          n;
        int          sess;
        int unsigned q_eff;
        int unsigned rounds;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        fail_cnt  = 0;
        cmds_sent = 0;
        no_gaps   = 1'b0;
        clear_table();
        quantum_q = QUANTUM_RESET;

        dir_rows = '{
            mk_done(),
            mk_load(16'hFFFF, 24'hFF_FFFF),
            mk_load(16'h0001, 24'd1),
            mk_load(16'h5A5A, 24'd0),
            mk_load(16'h8000, 24'd5),
            mk_slice(16'hFFFF, 0, 24'd4, 1'b0, '0),
            mk_slice(16'h0001, 1, 24'd1, 1'b1, 30'd1),
            mk_slice(16'h8000, 3, 24'd4, 1'b0, '0),
            mk_disp(),
            mk_slice(16'h8000, 3, 24'd1, 1'b1, 30'd9),
            mk_quantum(24'hFF_FFFF),
            mk_disp(),
            mk_done(),
            mk_quantum(24'd0),
            mk_load(16'hAAAA, 24'd2),
            mk_load(16'h5555, 24'd1),
            mk_slice(16'hAAAA, 0, 24'd1, 1'b0, '0),
            mk_disp(),
            mk_disp(),
            mk_done(),
            mk_done(),
            mk_quantum(24'd1)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (dir_rows[i].is_cfg)
                write_quantum(dir_rows[i].cfg_val);
            else
                issue_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want, got);
        end

        sess = 0;
        while (cmds_sent < TARGET_CMDS)
        begin
            if (sess == 0 || $urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       write_quantum('0);
                    1:       write_quantum(24'd1);
                    2:       write_quantum(24'hFF_FFFF);
                    3:       write_quantum(BURST_W'($urandom));
                    default: write_quantum(BURST_W'($urandom_range(1, 8)));
                endcase
            end
            q_eff   = (quantum_q == '0) ? 1 : quantum_q;
            no_gaps = ($urandom_range(0, 3) == 0);
            rounds  = 3;
            if (sess == 2 || $urandom_range(0, 14) == 0)
            begin
                n      = $urandom_range(MAX_PROCS, MAX_PROCS + 2);
                rounds = 1;
            end
            else if ($urandom_range(0, 9) == 0)
                n = 0;
            else
                n = $urandom_range(1, 10);

            for (int k = 0; k < n; k++)
                issue_cmd(rand_load(q_eff, rounds), 1'b0, '0, got);

            // dispatch until the table reports all_done, with a few late loads mixed in
            do
            begin
                if ($urandom_range(0, 5) == 0)
                    issue_cmd(rand_load(q_eff, rounds), 1'b0, '0, got);
                issue_cmd(rand_dispatch(), 1'b0, '0, got);
            end
            while (!got.all_done);
            sess++;
        end

        drain_and_hold();
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
